// ----- design/lept_pkg.sv -----
// Shared types, constants and register codes for the lane edge point tracker.
package lept_pkg;

	// Default for the widest row the tracker handles.
	localparam int MAX_WIDTH_DEF = 1024;

	// Width used for column and width comparisons; it covers every legal MAX_WIDTH plus one.
	localparam int CMP_W = 13;

	// Field widths.
	localparam int ROW_W     = 10;
	localparam int COL_OUT_W = 10;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;

	// Result fields and the byte-padded width of the result bus.
	localparam int RES_W     = 2*COL_OUT_W + 3;
	localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

	// Rows after the tracking row that are also checked for the previous column.
	localparam int TRACK_SPAN = 3;

	// Register reset values.
	localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST = 11'd640;
	localparam logic [ROW_W-1:0] INIT_ROW_RST    = 10'd400;
	localparam logic [ROW_W-1:0] TRACK_ROW_RST   = 10'd300;
	localparam logic [ROW_W-1:0] WINDOW_RST      = 10'd30;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH = 2'd0,
		CFG_INIT_ROW    = 2'd1,
		CFG_TRACK_ROW   = 2'd2,
		CFG_WINDOW      = 2'd3
	} cfg_reg_t;

	// Current register settings.
	typedef struct packed {
		logic [CFG_W-1:0] image_width;
		logic [ROW_W-1:0] init_row;
		logic [ROW_W-1:0] track_row;
		logic [ROW_W-1:0] window;
	} cfg_t;

	// One per-frame result, left_col in the lowest bits and tracking in the highest.
	typedef struct packed {
		logic                 tracking;
		logic                 right_broken;
		logic                 left_broken;
		logic [COL_OUT_W-1:0] right_col;
		logic [COL_OUT_W-1:0] left_col;
	} result_t;

endpackage

// ----- design/lept_scan.sv -----
// Per-pixel scan logic: position counters, hit registers and the frame-end decision.
module lept_scan
	import lept_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    px_fire,
	input  logic    px_white,
	input  logic    px_last,
	output result_t res
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic             init_q;
	logic [CW-1:0]    left_prev_q, right_prev_q;
	logic [CW-1:0]    lg_hit_q, lw_hit_q, rg_hit_q, rw_hit_q;
	logic             lg_ok_q, lw_ok_q, rg_ok_q, rw_ok_q;
	logic [1:0]       seen_q;

	logic [CMP_W-1:0] iw, w, c13;
	logic             c_ge1, c_ge2, c_lt_w, c1_lt_w, row_wrap;
	logic             on_init, on_track, in_track_rows, left_near, right_near;
	logic [CW-1:0]    lg_hit_n, lw_hit_n, rg_hit_n, rw_hit_n;
	logic             lg_ok_n, lw_ok_n, rg_ok_n, rw_ok_n;
	logic [1:0]       seen_n;
	logic [CW-1:0]    lc, rc;
	logic             lb, rb;

	// Distance between two columns, always non-negative.
	function automatic logic [CW-1:0] col_dist(input logic [CW-1:0] a, input logic [CW-1:0] b);
		col_dist = (a >= b) ? (a - b) : (b - a);
	endfunction

	// Effective row width, held between one and MAX_WIDTH.
	always_comb begin
		iw = CMP_W'(cfg.image_width);
		if (iw == '0) begin
			w = CMP_W'(1);
		end else if (iw > CMP_W'(MAX_WIDTH)) begin
			w = CMP_W'(MAX_WIDTH);
		end else begin
			w = iw;
		end
	end

	// Position tests for the current pixel.
	always_comb begin
		c13           = CMP_W'(col_q);
		c_ge1         = (col_q != '0);
		c_ge2         = (c13 >= CMP_W'(2));
		c_lt_w        = (c13 < w);
		c1_lt_w       = ((c13 + CMP_W'(1)) < w);
		row_wrap      = ((c13 + CMP_W'(1)) >= w);
		on_init       = (row_q == cfg.init_row);
		on_track      = (row_q == cfg.track_row);
		in_track_rows = ({1'b0, row_q} >= {1'b0, cfg.track_row}) &&
		                ({1'b0, row_q} <= ({1'b0, cfg.track_row} + (ROW_W+1)'(TRACK_SPAN)));
		left_near     = (CMP_W'(col_dist(col_q, left_prev_q)) <= CMP_W'(cfg.window));
		right_near    = (CMP_W'(col_dist(col_q, right_prev_q)) <= CMP_W'(cfg.window));
	end

	// Hit register updates for a white pixel.
	always_comb begin
		lg_hit_n = lg_hit_q;
		lw_hit_n = lw_hit_q;
		rg_hit_n = rg_hit_q;
		rw_hit_n = rw_hit_q;
		lg_ok_n  = lg_ok_q;
		lw_ok_n  = lw_ok_q;
		rg_ok_n  = rg_ok_q;
		rw_ok_n  = rw_ok_q;
		seen_n   = seen_q;
		if (px_white) begin
			if (!init_q) begin
				// Initial search: first white from each edge, past column zero.
				if (on_init) begin
					if (c_ge1 && c1_lt_w && !lw_ok_q) begin
						lw_hit_n = col_q;
						lw_ok_n  = 1'b1;
					end
					if (c_ge2 && c_lt_w) begin
						rw_hit_n = col_q;
						rw_ok_n  = 1'b1;
					end
				end
			end else begin
				// Continuity check on the previous columns.
				if (in_track_rows) begin
					if (col_q == left_prev_q) begin
						seen_n[0] = 1'b1;
					end
					if (col_q == right_prev_q) begin
						seen_n[1] = 1'b1;
					end
				end
				// Tracking row: whole-row and windowed searches for both sides.
				if (on_track) begin
					if (c_ge1 && c_lt_w && !lg_ok_q) begin
						lg_hit_n = col_q;
						lg_ok_n  = 1'b1;
					end
					if (c_ge1 && c1_lt_w && !lw_ok_q && left_near) begin
						lw_hit_n = col_q;
						lw_ok_n  = 1'b1;
					end
					if (c_ge1 && c_lt_w) begin
						rg_hit_n = col_q;
						rg_ok_n  = 1'b1;
					end
					if (c_ge2 && c_lt_w && right_near) begin
						rw_hit_n = col_q;
						rw_ok_n  = 1'b1;
					end
				end
			end
		end
	end

	// Frame-end choice of left and right columns.
	always_comb begin
		lb = 1'b0;
		rb = 1'b0;
		if (!init_q) begin
			// With no hit each side falls back to the other side's previous column.
			lc = lw_ok_n ? lw_hit_n : right_prev_q;
			rc = rw_ok_n ? rw_hit_n : left_prev_q;
		end else begin
			lb = !seen_n[0];
			rb = !seen_n[1];
			if (lb) begin
				lc = lg_ok_n ? lg_hit_n : left_prev_q;
			end else begin
				lc = lw_ok_n ? lw_hit_n : left_prev_q;
			end
			if (rb) begin
				rc = rg_ok_n ? rg_hit_n : right_prev_q;
			end else begin
				rc = rw_ok_n ? rw_hit_n : right_prev_q;
			end
		end
		res.left_col     = COL_OUT_W'(lc);
		res.right_col    = COL_OUT_W'(rc);
		res.left_broken  = lb;
		res.right_broken = rb;
		res.tracking     = init_q;
	end

	// State update, once per pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			init_q       <= 1'b0;
			left_prev_q  <= '0;
			right_prev_q <= '0;
			lg_hit_q     <= '0;
			lw_hit_q     <= '0;
			rg_hit_q     <= '0;
			rw_hit_q     <= '0;
			lg_ok_q      <= 1'b0;
			lw_ok_q      <= 1'b0;
			rg_ok_q      <= 1'b0;
			rw_ok_q      <= 1'b0;
			seen_q       <= '0;
		end else if (px_fire) begin
			if (px_last) begin
				// Frame done: keep the chosen columns and start a fresh frame.
				left_prev_q  <= lc;
				right_prev_q <= rc;
				init_q       <= 1'b1;
				col_q        <= '0;
				row_q        <= '0;
				lg_ok_q      <= 1'b0;
				lw_ok_q      <= 1'b0;
				rg_ok_q      <= 1'b0;
				rw_ok_q      <= 1'b0;
				seen_q       <= '0;
			end else begin
				lg_hit_q <= lg_hit_n;
				lw_hit_q <= lw_hit_n;
				rg_hit_q <= rg_hit_n;
				rw_hit_q <= rw_hit_n;
				lg_ok_q  <= lg_ok_n;
				lw_ok_q  <= lw_ok_n;
				rg_ok_q  <= rg_ok_n;
				rw_ok_q  <= rw_ok_n;
				seen_q   <= seen_n;
				if (row_wrap) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

endmodule

// ----- design/lept_out_reg.sv -----
// Output register holding one result request until the downstream side takes it.
module lept_out_reg
	import lept_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  result_t              res,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata // left_col, right_col, left_broken, right_broken, tracking, zero pad
);

	logic    valid_q;
	result_t res_q;

	// Valid flag: set on load, cleared once the request is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {{(M_TDATA_W-RES_W){1'b0}}, res_q};

endmodule

// ----- design/lane_edge_point_tracker.sv -----
// Top level of the lane edge point tracker: input stage, configuration and result output.
// Path: a frame-end pixel passes through the input register, then loads the output register,
// which raises m_tvalid and holds the result until m_tready takes it.
// Throughput: one pixel per cycle; the single input register stalls the input only when it
// holds a frame-end pixel and a finished result is still waiting to be taken.
// Reset: arst_n clears all counters, hit flags and valid flags at once, restores the
// register defaults and returns the tracker to its initial search frame.
module lane_edge_point_tracker
	import lept_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata, // white, zero pad
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [M_TDATA_W-1:0]   m_tdata, // left_col, right_col, left_broken, right_broken,
	                                        // tracking, zero pad
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	cfg_t    cfg_q;
	logic    valid_s1, white_s1, last_s1;
	logic    advance, fire;
	result_t res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width <= IMAGE_WIDTH_RST;
			cfg_q.init_row    <= INIT_ROW_RST;
			cfg_q.track_row   <= TRACK_ROW_RST;
			cfg_q.window      <= WINDOW_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_IMAGE_WIDTH: cfg_q.image_width <= cfg_data;
				CFG_INIT_ROW:    cfg_q.init_row    <= cfg_data[ROW_W-1:0];
				CFG_TRACK_ROW:   cfg_q.track_row   <= cfg_data[ROW_W-1:0];
				CFG_WINDOW:      cfg_q.window      <= cfg_data[ROW_W-1:0];
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	// The input stage moves on unless it holds a frame end and the output is still full.
	assign advance  = !valid_s1 || !last_s1 || !m_tvalid || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s_tvalid) begin
			white_s1 <= s_tdata[0];
			last_s1  <= s_tlast;
		end
	end

	// Per-pixel scan.
	lept_scan #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.px_fire (fire),
		.px_white(white_s1),
		.px_last (last_s1),
		.res     (res)
	);

	// Result output.
	lept_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (fire && last_s1),
		.res     (res),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule
